// ===== rtl/b64d_pkg.sv =====
// Shared types, character codes and the character class table for the
// Base64 stream decoder. No dependencies.
package b64d_pkg;

   // Default character limit for one message (after leading blanks)
   localparam int unsigned MAX_CHARS_DEF = 4096;

   // Result queue depth; an item can push two results
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_IDX_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_DASH  = 8'h2D;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] NON_ASCII = 8'h80;

   // Class codes; sextets are 0..63, anything with bit 7 set is a class
   localparam logic [7:0] CLS_BLANK      = 8'hE0;
   localparam logic [7:0] CLS_LF         = 8'hF0;
   localparam logic [7:0] CLS_CR         = 8'hF1;
   localparam logic [7:0] CLS_DASH       = 8'hF2;
   localparam logic [7:0] CLS_INVALID    = 8'hFF;
   localparam logic [7:0] CLS_TRAIL_MASK = 8'h13;
   localparam logic [7:0] CLS_TRAIL      = 8'hF3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_final;
      logic        error_flag;
      logic [11:0] byte_count;
   } rsp_type;

   // Results written into the queue for one item, in this order
   typedef struct packed {
      logic data_en;
      logic final_en;
   } push_type;

   function automatic logic [7:0] b64d_char_class(input logic [7:0] c);
      logic [7:0] cls;
      cls = CLS_INVALID;
      if (c >= 8'h41 && c <= 8'h5A)      cls = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) cls = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) cls = c - 8'h30 + 8'd52;
      else if (c == CHR_PLUS)            cls = 8'd62;
      else if (c == CHR_SLASH)           cls = 8'd63;
      else if (c == CHR_TAB || c == CHR_SPACE) cls = CLS_BLANK;
      else if (c == CHR_LF)              cls = CLS_LF;
      else if (c == CHR_CR)              cls = CLS_CR;
      else if (c == CHR_DASH)            cls = CLS_DASH;
      return cls;
   endfunction

endpackage

// ===== rtl/b64d_decode.sv =====
// Per-message decode state and the single-pass decode of one character.
// Depends on b64d_pkg.
module b64d_decode #(
   parameter int unsigned MaxChars = b64d_pkg::MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  b64d_pkg::req_type item,
   output b64d_pkg::push_type push,
   output b64d_pkg::rsp_type data_item,
   output b64d_pkg::rsp_type final_item
);
   import b64d_pkg::*;

   localparam int unsigned LenW = $clog2(MaxChars + 1);
   localparam logic [LenW-1:0] MaxLen = LenW'(MaxChars);

   logic            lead_ff, lead_in;
   logic            pad_ff, pad_in;
   logic            err_ff, err_in;
   logic [1:0]      pos_ff, pos_in;
   logic [5:0]      hold_ff, hold_in;   // previous sextet
   logic [LenW-1:0] total_ff, total_in;
   logic [LenW-1:0] trail_ff, trail_in;
   logic [11:0]     dec_ff, dec_in;

   logic [7:0]      cls;
   logic            is_pad;
   logic            lead_blank;
   logic [LenW-1:0] kept;

   always_comb begin
      lead_in    = lead_ff;
      pad_in     = pad_ff;
      err_in     = err_ff;
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      total_in   = total_ff;
      trail_in   = trail_ff;
      dec_in     = dec_ff;
      push       = '0;
      data_item  = '0;
      final_item = '0;
      kept       = '0;
      cls        = b64d_char_class(item.char_code);
      is_pad     = item.char_code == CHR_PAD;
      lead_blank = item.char_code == CHR_TAB || item.char_code == CHR_SPACE;

      if (fire) begin
         if (!(lead_ff && lead_blank)) begin
            lead_in = 1'b0;
            if (total_ff >= MaxLen) begin
               err_in = 1'b1;
            end else begin
               total_in = total_ff + 1'b1;
               if ((item.char_code & NON_ASCII) != 8'h00) begin
                  err_in   = 1'b1;
                  trail_in = '0;
               end else if (!is_pad && (cls | CLS_TRAIL_MASK) == CLS_TRAIL) begin
                  trail_in = trail_ff + 1'b1;
               end else begin
                  if (!pad_ff && !err_ff) begin
                     if (trail_ff != '0) begin
                        err_in = 1'b1;
                     end else if (is_pad) begin
                        if (pos_ff < 2'd2) err_in = 1'b1;
                        else               pad_in = 1'b1;
                     end else if (cls[7]) begin
                        err_in = 1'b1;
                     end else begin
                        case (pos_ff)
                           2'd1:    data_item.out_byte = {hold_ff, cls[5:4]};
                           2'd2:    data_item.out_byte = {hold_ff[3:0], cls[5:2]};
                           2'd3:    data_item.out_byte = {hold_ff[1:0], cls[5:0]};
                           default: data_item.out_byte = '0;
                        endcase
                        if (pos_ff != 2'd0) begin
                           push.data_en = 1'b1;
                           dec_in       = dec_ff + 1'b1;
                        end
                        hold_in = cls[5:0];
                        pos_in  = pos_ff + 1'b1;
                     end
                  end
                  trail_in = '0;
               end
            end
         end

         if (item.last_char) begin
            kept                  = total_in - trail_in;
            push.final_en         = 1'b1;
            final_item.is_final   = 1'b1;
            final_item.error_flag = err_in || kept[1:0] != 2'd0 ||
                                    (kept == '0 && total_in != '0);
            final_item.byte_count = dec_in;
            lead_in  = 1'b1;
            pad_in   = 1'b0;
            err_in   = 1'b0;
            pos_in   = '0;
            hold_in  = '0;
            total_in = '0;
            trail_in = '0;
            dec_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 1'b1;
         pad_ff   <= 1'b0;
         err_ff   <= 1'b0;
         pos_ff   <= '0;
         hold_ff  <= '0;
         total_ff <= '0;
         trail_ff <= '0;
         dec_ff   <= '0;
      end else begin
         lead_ff  <= lead_in;
         pad_ff   <= pad_in;
         err_ff   <= err_in;
         pos_ff   <= pos_in;
         hold_ff  <= hold_in;
         total_ff <= total_in;
         trail_ff <= trail_in;
         dec_ff   <= dec_in;
      end
   end

   // message end returns the decoder to its idle state
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_char |=> lead_ff && total_ff == '0 && dec_ff == '0 && !err_ff)
      else $error("decode state not cleared after last character");

   // no data after a pad or an error
   a_no_data_after_stop: assert property (@(posedge clock) disable iff (reset)
      push.data_en |-> !pad_ff && !err_ff)
      else $error("data byte produced after pad or error");

   // trailing run never outgrows the counted length
   a_trail_le_total: assert property (@(posedge clock) disable iff (reset)
      trail_ff <= total_ff)
      else $error("trailing run exceeds total length");

endmodule

// ===== rtl/b64d_out_queue.sv =====
// Small result queue: takes up to two results per cycle, hands out one
// unless rsp_stall is set. Depends on b64d_pkg.
module b64d_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::push_type push,
   input  b64d_pkg::rsp_type  data_item,
   input  b64d_pkg::rsp_type  final_item,
   output logic               room2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64d_pkg::rsp_type  rsp_item
);
   import b64d_pkg::*;

   rsp_type              entry_ff [RSP_DEPTH];
   logic [RSP_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_IDX_W-1:0] final_idx;
   logic                 pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign room2     = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign pop       = rsp_valid && !rsp_stall;
   assign final_idx = push.data_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_IDX_W'(push.data_en) + RSP_IDX_W'(push.final_en);
      rd_ptr_in = rd_ptr_ff + RSP_IDX_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.data_en) + RSP_CNT_W'(push.final_en)
                  - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.data_en)  entry_ff[wr_ptr_ff] <= data_item;
      if (push.final_en) entry_ff[final_idx] <= final_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.data_en || push.final_en) |-> room2)
      else $error("push into result queue without room");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the Base64 stream decoder: input register, decode stage and
// result queue. Depends on b64d_pkg, b64d_decode, b64d_out_queue.
//
// Streaming Base64 decoder. One character is taken per item on the req_
// channel, last_char marking the end of a message. Leading tabs and spaces
// are skipped; a trailing run of tab, space, CR, LF or '-' is dropped as
// long as four characters remain. Every four characters of the standard
// alphabet give three bytes, each sent as a data item (is_final = 0) on
// the rsp_ channel as soon as it is known; '=' in the third or fourth
// place ends decoding. After the last character a status item follows
// (is_final = 1) with error_flag and byte_count; on error the consumer
// drops the data bytes of that message. Any byte at or above 0x80, an
// invalid character, a misplaced pad, a blank inside the text, a bad
// trimmed length or over MAX_CHARS counted characters sets the error flag.
// Rate: one character per cycle sustained while the result queue has room.
// Each item is held in the input register and decoded there in a single
// pass; its zero, one or two results go into a four-entry result queue,
// which drains one item per cycle unless the consumer stalls. The input
// stalls only when the queue cannot take two more results, which takes a
// consumer that holds off: with the consumer always ready the queue never
// holds more than two results, message ends included.
module base64_stream_decoder #(
   parameter int unsigned MAX_CHARS = b64d_pkg::MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp_item
);
   import b64d_pkg::*;

   // input register
   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     accept;

   // decode stage handshake
   logic     room2;
   logic     fire;
   push_type push;
   rsp_type  data_item;
   rsp_type  final_item;

   // the held item decodes as soon as the queue can take both its results
   assign fire      = in_valid_ff && room2;
   assign req_stall = in_valid_ff && !room2;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (fire)   in_valid_in = 1'b0;
      if (accept) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) in_item_ff <= req_item;
   end

   b64d_decode #(
      .MaxChars (MAX_CHARS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .push       (push),
      .data_item  (data_item),
      .final_item (final_item)
   );

   b64d_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .data_item  (data_item),
      .final_item (final_item),
      .room2      (room2),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // a held item that cannot decode stays put
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_item_ff))
      else $error("held character lost or changed");

   // status item pushed exactly when the last character decodes
   a_final_push: assert property (@(posedge clock) disable iff (reset)
      push.final_en == (fire && in_item_ff.last_char))
      else $error("status item push mismatch");

endmodule

// ===== sim/tb_base64_stream_decoder.sv =====
// Self-checking testbench for base64_stream_decoder: directed and random
// messages, random idling on both channels, a result-side hold-off.
// Depends on b64d_pkg and the base64_stream_decoder RTL.
module tb_base64_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam int unsigned CHAR_LIMIT = MAX_CHARS_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   base64_stream_decoder #(
      .MAX_CHARS(CHAR_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Decoder shadow state, one message at a time
   // ------------------------------------------------------------------
   logic [17:0] sextets;       // last three sextets of the group
   logic [1:0]  slot;          // place of the next character in its group
   logic        lead_skip;     // still in the leading tabs/spaces
   logic        pad_hit;       // '=' taken, rest is not decoded
   logic        bad_msg;       // data error somewhere in the message
   int unsigned msg_chars;     // counted characters (after leading blanks)
   int unsigned blank_run;     // current run of tab/space/LF/CR/'-'
   logic [11:0] byte_total;    // data bytes emitted so far

   rsp_type     decoded_fifo[$];   // data bytes and status items still due
   logic [7:0]  text_buf[$];       // message being sent
   int          fail_count = 0;
   bit          idle_on = 1'b1;    // random bursts of idling allowed
   int          hold_request = 0;  // long result-side hold, in cycles
   int          hold_left = 0;
   int          burst_left = 0;

   string alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   string trail_set = "\t \n\r-";

   task automatic clear_message();
      sextets    = '0;
      slot       = '0;
      lead_skip  = 1'b1;
      pad_hit    = 1'b0;
      bad_msg    = 1'b0;
      msg_chars  = 0;
      blank_run  = 0;
      byte_total = '0;
   endtask

   // Sextet value 0..63, or a class code with bit 7 set
   function automatic logic [7:0] class_of(input logic [7:0] code);
      logic [7:0] cls;
      cls = CLS_INVALID;
      case (code)
         CHR_TAB, CHR_SPACE: cls = CLS_BLANK;
         CHR_LF:             cls = CLS_LF;
         CHR_CR:             cls = CLS_CR;
         CHR_DASH:           cls = CLS_DASH;
         CHR_PLUS:           cls = 8'd62;
         CHR_SLASH:          cls = 8'd63;
         default: begin
            if (code >= "A" && code <= "Z")      cls = code - "A";
            else if (code >= "a" && code <= "z") cls = code - "a" + 8'd26;
            else if (code >= "0" && code <= "9") cls = code - "0" + 8'd52;
         end
      endcase
      return cls;
   endfunction

   // Work out what one accepted character produces
   task automatic decode_char(input logic [7:0] code, input logic last);
      logic [7:0]  cls;
      logic [7:0]  dbyte;
      int unsigned kept;
      rsp_type     status;
      cls = class_of(code);
      if (!(lead_skip && cls == CLS_BLANK)) begin
         lead_skip = 1'b0;
         if (msg_chars >= CHAR_LIMIT) begin
            // over the limit: flagged, not counted
            bad_msg = 1'b1;
         end else begin
            msg_chars++;
            if (code >= NON_ASCII) begin
               bad_msg   = 1'b1;
               blank_run = 0;
            end else if (code != CHR_PAD && (cls | CLS_TRAIL_MASK) == CLS_TRAIL) begin
               blank_run++;
            end else begin
               if (!pad_hit && !bad_msg) begin
                  if (blank_run != 0) begin
                     bad_msg = 1'b1;   // blank inside the text
                  end else if (code == CHR_PAD) begin
                     if (slot < 2'd2) bad_msg = 1'b1;
                     else             pad_hit = 1'b1;
                  end else if (cls[7]) begin
                     bad_msg = 1'b1;
                  end else begin
                     // a byte completes on every place but the first
                     if (slot != 2'd0) begin
                        case (slot)
                           2'd1:    dbyte = {sextets[5:0], cls[5:4]};
                           2'd2:    dbyte = {sextets[3:0], cls[5:2]};
                           default: dbyte = {sextets[1:0], cls[5:0]};
                        endcase
                        decoded_fifo.push_back(rsp_type'{out_byte: dbyte,
                                                         is_final: 1'b0,
                                                         error_flag: 1'b0,
                                                         byte_count: 12'd0});
                        byte_total++;
                     end
                     sextets = {sextets[11:0], cls[5:0]};
                     slot    = slot + 2'd1;
                  end
               end
               blank_run = 0;
            end
         end
      end
      if (last) begin
         kept = msg_chars - blank_run;
         status.out_byte   = 8'h00;
         status.is_final   = 1'b1;
         status.error_flag = bad_msg || (kept % 4 != 0) || (kept == 0 && msg_chars != 0);
         status.byte_count = byte_total;
         decoded_fifo.push_back(status);
         clear_message();
      end
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offer one item and hold it until taken; valid stays up for a
   // back-to-back item unless an idle burst is drawn.
   task automatic send_char(input logic [7:0] code, input logic last);
      req_item  <= '{char_code: code, last_char: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      decode_char(code, last);
      if (idle_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
   endtask

   task automatic send_buffer();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic load_text(input string text);
      text_buf.delete();
      for (int i = 0; i < text.len(); i++) text_buf.push_back(text[i]);
   endtask

   task automatic load_valid_chars(input int count);
      text_buf.delete();
      repeat (count) text_buf.push_back(alphabet[$urandom_range(0, 63)]);
   endtask

   // Sender goes quiet until every due result has come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_fifo.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Result side: idle bursts plus an optional long hold
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left != 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every taken result must match the oldest one due
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_fifo.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: byte %h final %b err %b count %0d",
                        rsp_item.out_byte, rsp_item.is_final,
                        rsp_item.error_flag, rsp_item.byte_count);
         end else begin
            want = decoded_fifo.pop_front();
            if (rsp_item.out_byte !== want.out_byte || rsp_item.is_final !== want.is_final ||
                rsp_item.error_flag !== want.error_flag ||
                rsp_item.byte_count !== want.byte_count) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result differs: exp byte %h final %b err %b count %0d, ",
                           want.out_byte, want.is_final, want.error_flag, want.byte_count,
                           "got byte %h final %b err %b count %0d",
                           rsp_item.out_byte, rsp_item.is_final, rsp_item.error_flag,
                           rsp_item.byte_count);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Sextet extremes 63 and 0, every alphabet range, pad in the last place
   task automatic test_decode_basic();
      load_text("/+9zAa0="); send_buffer();
   endtask

   task automatic test_whitespace();
      // leading tab/space skipped, trailing LF and dash trimmed
      load_text(" \tTWE=\n-"); send_buffer();
      // LF followed by more text is an error
      load_text("AB\nD"); send_buffer();
      // only leading blanks: zero bytes, no error
      load_text(" \t"); send_buffer();
   endtask

   task automatic test_padding();
      // pad in the third place; what follows counts but is not decoded
      load_text("QQ=A"); send_buffer();
      // pad in the second place
      load_text("A="); send_buffer();
   endtask

   task automatic test_invalid_chars();
      load_text("A*"); send_buffer();
      // non-ASCII still counts after a pad
      load_text("QQ="); text_buf.push_back(NON_ASCII); send_buffer();
      text_buf = {8'hFF}; send_buffer();
   endtask

   task automatic test_message_length();
      // trimmed to three characters: a bad length
      load_text("ABC\n"); send_buffer();
      // nothing but a trailing character
      load_text("-"); send_buffer();
   endtask

   // Result side held off for a long time while characters keep coming,
   // so the result queue fills and the input stalls.
   task automatic test_backpressure();
      bit saved;
      saved        = idle_on;
      idle_on      = 1'b0;
      hold_request = 60;
      load_valid_chars(24); send_buffer();
      idle_on      = saved;
   endtask

   // Mostly well-formed messages with random content; some with one
   // corrupted character, some pure noise.
   task automatic build_random_message();
      int pad_n;
      int pos;
      text_buf.delete();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2))
            text_buf.push_back($urandom_range(0, 1) ? CHR_TAB : CHR_SPACE);
         repeat (4 * $urandom_range(1, 3)) text_buf.push_back(alphabet[$urandom_range(0, 63)]);
         pad_n = $urandom_range(0, 2);
         for (int i = 0; i < pad_n; i++) text_buf[text_buf.size() - 1 - i] = CHR_PAD;
         repeat ($urandom_range(0, 2)) text_buf.push_back(trail_set[$urandom_range(0, 4)]);
         if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            text_buf[pos] = 8'($urandom_range(0, 255));
         end
      end
   endtask

   task automatic test_random_messages(input int item_target);
      int sent;
      sent = 0;
      while (sent < item_target) begin
         build_random_message();
         sent += text_buf.size();
         send_buffer();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_decode_basic();      wait_results_drained();
      test_whitespace();        wait_results_drained();
      test_padding();           wait_results_drained();
      test_invalid_chars();     wait_results_drained();
      test_message_length();    wait_results_drained();
      test_backpressure();      wait_results_drained();
      test_random_messages(35); wait_results_drained();
      // closing stretch runs flat out
      idle_on = 1'b0;
      test_random_messages(20); wait_results_drained();

      // any stray result after the last one would show up here
      repeat (8) @(posedge clock);
      if (fail_count == 0 && decoded_fifo.size() == 0) begin
         $display("base64_stream_decoder: match");
      end else begin
         $display("base64_stream_decoder: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("base64_stream_decoder: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_out_queue.sv
rtl/base64_stream_decoder.sv
sim/tb_base64_stream_decoder.sv
